/* rtl/lpkt_pkg.sv */
// ----------------------------------------------------------------------------
// lpkt_pkg
// Types and codes shared by the linear-probing key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 12;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSED   = 3'd4;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic home_ld;
        logic advance;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic term;
        logic res_free;
    } stat_t;

endpackage

/* rtl/lpkt_ram.sv */
// ----------------------------------------------------------------------------
// lpkt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lpkt_ctrl.sv */
// ----------------------------------------------------------------------------
// lpkt_ctrl
// Sequencer for the key table: clearing pass, home slot, probe walk.
// ----------------------------------------------------------------------------
module lpkt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lpkt_pkg::stat_t st,
    output lpkt_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HOME  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                if (st.mod_done)
                begin
                    cmd.home_ld = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.term)
                begin
                    if (st.res_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/lpkt_dpath.sv */
// ----------------------------------------------------------------------------
// lpkt_dpath
// Key table datapath: slot store, home slot remainder, probe address and
// count, match test, result register.
// ----------------------------------------------------------------------------
module lpkt_dpath #(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lpkt_pkg::req_t  req,
    input  lpkt_pkg::cmd_t  cmd,
    output lpkt_pkg::stat_t st,
    output lpkt_pkg::rsp_t  rsp,
    output logic           rsp_valid,
    input  logic           rsp_ready
);

    localparam int IDX_W     = $clog2(TABLE_SLOTS);
    localparam int SLOT_EX_W = (IDX_W > lpkt_pkg::SLOT_W) ? IDX_W : lpkt_pkg::SLOT_W;
    localparam bit IS_POW2   = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam int ENTRY_W   = $bits(lpkt_pkg::entry_t);

    logic                       req_type_reg;
    logic [lpkt_pkg::KEY_W-1:0] key_reg;
    logic [IDX_W-1:0]           home_idx;
    logic                       mod_done;

    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] probe_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] probe_next;

    lpkt_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;

    lpkt_pkg::entry_t ent;
    lpkt_pkg::entry_t wr_ent;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic hit;
    logic empty;
    logic last;
    logic wr_need;
    logic res_free;
    logic [lpkt_pkg::STATUS_W-1:0] res_status;
    logic [SLOT_EX_W-1:0]          slot_ex;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req.req_type;
            key_reg      <= req.key;
        end
    end

    generate
        if (IS_POW2)
        begin : g_mask
            assign home_idx = key_reg[IDX_W-1:0];
            assign mod_done = 1'b1;
        end
        else
        begin : g_recip
            localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_SLOTS);
            localparam logic [lpkt_pkg::KEY_W-1:0] RECIP =
                lpkt_pkg::KEY_W'((64'd1 << lpkt_pkg::KEY_W) / TABLE_SLOTS);

            logic [1:0]                     step_reg;
            logic [2*lpkt_pkg::KEY_W-1:0]   prod;
            logic [IDX_W:0]                 quot_reg;
            logic [2*IDX_W+1:0]             quot_mul;
            logic [IDX_W:0]                 rem_reg;

            // quotient estimate is exact or one short; fix with one subtract
            assign prod     = key_reg * RECIP;
            assign quot_mul = quot_reg * MODULUS;
            assign mod_done = (step_reg == 2'd2);
            assign home_idx = (rem_reg >= MODULUS) ? IDX_W'(rem_reg - MODULUS)
                                                   : rem_reg[IDX_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= '0;
                end
                else if (cmd.load)
                begin
                    step_reg <= '0;
                end
                else if (!mod_done)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (step_reg == 2'd0)
                begin
                    quot_reg <= prod[lpkt_pkg::KEY_W +: IDX_W + 1];
                end
                if (step_reg == 2'd1)
                begin
                    rem_reg <= key_reg[IDX_W:0] - quot_mul[IDX_W:0];
                end
            end
        end
    endgenerate

    assign probe_next = (probe_reg == LAST_IDX) ? '0 : probe_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.home_ld)
        begin
            probe_reg <= home_idx;
            cnt_reg   <= '0;
        end
        else if (cmd.advance)
        begin
            probe_reg <= probe_next;
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign ent   = lpkt_pkg::entry_t'(rd_data);
    assign hit   = ent.valid && (ent.key == key_reg);
    assign empty = !ent.valid;
    assign last  = (cnt_reg == LAST_IDX);

    always_comb
    begin
        wr_need    = 1'b0;
        wr_ent     = '0;
        res_status = lpkt_pkg::ST_MISSED;
        if (req_type_reg == lpkt_pkg::REQ_INSERT)
        begin
            priority if (hit)
            begin
                res_status = lpkt_pkg::ST_FOUND;
            end
            else if (empty)
            begin
                res_status   = lpkt_pkg::ST_INSERTED;
                wr_need      = 1'b1;
                wr_ent.valid = 1'b1;
                wr_ent.key   = key_reg;
            end
            else
            begin
                res_status = lpkt_pkg::ST_FULL;
            end
        end
        else if (hit)
        begin
            res_status = lpkt_pkg::ST_REMOVED;
            wr_need    = 1'b1;
        end
    end

    assign slot_ex = (hit || wr_need) ? SLOT_EX_W'(probe_reg) : '0;

    assign res_free = !rsp_valid_reg || rsp_ready;

    assign st.clear_last = (clr_reg == LAST_IDX);
    assign st.mod_done   = mod_done;
    assign st.term       = hit || last || ((req_type_reg == lpkt_pkg::REQ_INSERT) && empty);
    assign st.res_free   = res_free;

    assign wr_en   = cmd.clear_wr || (cmd.finish && wr_need);
    assign wr_addr = cmd.clear_wr ? clr_reg : probe_reg;
    assign rd_en   = cmd.home_ld || cmd.advance;
    assign rd_addr = cmd.home_ld ? home_idx : probe_next;

    lpkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.clear_wr ? {ENTRY_W{1'b0}} : wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.status <= res_status;
            rsp_reg.slot   <= slot_ex[lpkt_pkg::SLOT_W-1:0];
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> res_free)
        else $error("result loaded over an untaken beat");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid_reg)
        else $error("result beat not raised after finish");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !last)
        else $error("probe walk went past the table size");

    a_home_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.home_ld |-> mod_done)
        else $error("home slot taken before remainder settled");
`endif

endmodule

/* rtl/linear_probe_key_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_key_table
// Open-addressing key table with linear probing for process-id keys.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot RAM once to clear every entry, with
// req_ready low. A request is then taken in the idle cycle, its home slot is
// formed (key modulo TABLE_SLOTS, a bit mask when TABLE_SLOTS is a power of
// two, otherwise a reciprocal multiply and a correcting subtract), and then
// one slot is probed per cycle, set by the single read port of the slot RAM
// with its registered read; the walk holds at its end while an earlier result
// still waits on rsp_ready. A remove of an absent key walks all TABLE_SLOTS
// slots. The result sits in an output register, so the next request may be
// taken while it waits on rsp_ready.
// ----------------------------------------------------------------------------
module linear_probe_key_table #(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lpkt_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lpkt_pkg::rsp_t  rsp
);

    lpkt_pkg::cmd_t  cmd;
    lpkt_pkg::stat_t st;

    lpkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    lpkt_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probing key table.
// ----------------------------------------------------------------------------
// Requests go in on a valid/ready channel with random gaps. A shadow copy of
// the slot array is updated as each request is accepted, and it gives the
// status and slot to expect. Responses are taken with random stalls and are
// checked in order against those expectations. The tests cover directed
// probe walks across the wrap point with holes and duplicate copies, and
// random traffic on clustered keys.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_SLOTS = 4096;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    lpkt_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    lpkt_pkg::rsp_t rsp;

    bit                         mirror_used [TABLE_SLOTS];
    logic [lpkt_pkg::KEY_W-1:0] mirror_key  [TABLE_SLOTS];
    lpkt_pkg::rsp_t             pending_outcomes [$];
    int                         fault_count = 0;
    bit                         gaps_on = 1'b1;

    always #2 clk = ~clk;

    linear_probe_key_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(0, 6)) : 0;
    endfunction

    function automatic int locate_key(logic [lpkt_pkg::KEY_W-1:0] k);
        int home;
        int p;
        home = int'(k % TABLE_SLOTS);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            p = (home + i) % TABLE_SLOTS;
            if (mirror_used[p] && mirror_key[p] == k)
                return p;
        end
        return -1;
    endfunction

    // Walk the shadow table as the block does and apply the change.
    function automatic lpkt_pkg::rsp_t probe_table(lpkt_pkg::req_t r);
        lpkt_pkg::rsp_t res;
        int             home;
        int             p;
        home       = int'(r.key % TABLE_SLOTS);
        res.status = (r.req_type == lpkt_pkg::REQ_INSERT) ? lpkt_pkg::ST_FULL
                                                         : lpkt_pkg::ST_MISSED;
        res.slot   = '0;
        if (r.req_type == lpkt_pkg::REQ_REMOVE)
        begin
            p = locate_key(r.key);
            if (p >= 0)
            begin
                mirror_used[p] = 1'b0;
                res.status     = lpkt_pkg::ST_REMOVED;
                res.slot       = lpkt_pkg::SLOT_W'(p);
            end
            return res;
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            p = (home + i) % TABLE_SLOTS;
            if (mirror_used[p] && mirror_key[p] == r.key)
            begin
                res.status = lpkt_pkg::ST_FOUND;
                res.slot   = lpkt_pkg::SLOT_W'(p);
                return res;
            end
            if (!mirror_used[p])
            begin
                mirror_used[p] = 1'b1;
                mirror_key[p]  = r.key;
                res.status     = lpkt_pkg::ST_INSERTED;
                res.slot       = lpkt_pkg::SLOT_W'(p);
                return res;
            end
        end
        return res;
    endfunction

    task automatic flag_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic issue_request(logic kind, logic [lpkt_pkg::KEY_W-1:0] k);
        lpkt_pkg::req_t beat;
        int             gap;
        beat.req_type = kind;
        beat.key      = k;
        gap           = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do @(posedge clk); while (req_ready !== 1'b1);
        pending_outcomes.push_back(probe_table(beat));
    endtask

    function automatic logic [lpkt_pkg::KEY_W-1:0] key_at_home(int home);
        return lpkt_pkg::KEY_W'(($urandom() >> 13) * TABLE_SLOTS + home);
    endfunction

    function automatic logic [lpkt_pkg::KEY_W-1:0] absent_key();
        logic [lpkt_pkg::KEY_W-1:0] k;
        do k = lpkt_pkg::KEY_W'($urandom()); while (locate_key(k) >= 0);
        return k;
    endfunction

    task automatic test_directed_walks();
        gaps_on = 1'b1;
        issue_request(lpkt_pkg::REQ_INSERT, 31'd0);
        issue_request(lpkt_pkg::REQ_INSERT, 31'd0);
        issue_request(lpkt_pkg::REQ_INSERT, 31'h7FFF_FFFF);
        issue_request(lpkt_pkg::REQ_INSERT, 31'd4096);
        // wraps past the top slot into the cluster at slot 0
        issue_request(lpkt_pkg::REQ_INSERT, 31'd8191);
        issue_request(lpkt_pkg::REQ_INSERT, 31'd8191);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'd0);
        issue_request(lpkt_pkg::REQ_INSERT, 31'd8191);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'd8191);
        // hole at slot 0 gives a second copy
        issue_request(lpkt_pkg::REQ_INSERT, 31'd4096);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'd4096);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'd4096);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'd4096);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'd8191);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'h7FFF_FFFF);
        issue_request(lpkt_pkg::REQ_INSERT, 31'h2AAA_AAAA);
        issue_request(lpkt_pkg::REQ_INSERT, 31'h5555_5555);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'h2AAA_AAAA);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'h5555_5555);
        issue_request(lpkt_pkg::REQ_REMOVE, 31'h5555_5555);
    endtask

    task automatic test_random_traffic();
        logic [lpkt_pkg::KEY_W-1:0] pool [40];
        int                         misses_left;
        int                         roll;
        int                         pick;
        int                         hit;
        misses_left = 60;
        // most keys crowd a few home slots either side of the wrap
        for (int n = 0; n < 40; n++)
        begin
            if (n < 32)
                pool[n] = key_at_home((TABLE_SLOTS - 6 + $urandom_range(0, 11)) % TABLE_SLOTS);
            else
                pool[n] = lpkt_pkg::KEY_W'($urandom());
        end
        for (int n = 0; n < 1530; n++)
        begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 39);
            hit  = -1;
            if (roll >= 65 && roll < 95)
            begin
                for (int j = 0; j < 40 && hit < 0; j++)
                    if (locate_key(pool[(pick + j) % 40]) >= 0)
                        hit = (pick + j) % 40;
            end
            if (roll < 10)
                issue_request(lpkt_pkg::REQ_INSERT, lpkt_pkg::KEY_W'($urandom()));
            else if (hit >= 0)
                issue_request(lpkt_pkg::REQ_REMOVE, pool[hit]);
            else if (roll >= 95 && misses_left > 0)
            begin
                misses_left--;
                issue_request(lpkt_pkg::REQ_REMOVE, absent_key());
            end
            else
                issue_request(lpkt_pkg::REQ_INSERT, pool[pick]);
        end
    endtask

    initial
    begin : rsp_side
        lpkt_pkg::rsp_t want;
        int             gap;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            if (pending_outcomes.size() == 0)
                flag_fault($sformatf("unexpected beat: status %0d slot %0d",
                                     rsp.status, rsp.slot));
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp.status !== want.status)
                    flag_fault($sformatf("status expected %0d actual %0d",
                                         want.status, rsp.status));
                if (rsp.slot !== want.slot)
                    flag_fault($sformatf("slot expected %0d actual %0d",
                                         want.slot, rsp.slot));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("linear_probe_key_table verification failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            mirror_used[s] = 1'b0;
            mirror_key[s]  = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_walks();
        test_random_traffic();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (fault_count == 0)
            $display("linear_probe_key_table verification clean");
        else
            $display("linear_probe_key_table verification failed");
        $finish;
    end

endmodule
